FILE: design/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

FILE: design/edf_pkg.sv
// Package for the EDF scheduler: payload types, codes and control structs.
// Depends on nothing; used by every module of the block.
package edf_pkg;

  localparam int TableDepthDefault = 16;
  localparam int MaxResults        = 16;

  localparam logic [1:0] OUT_DONE   = 2'd0;
  localparam logic [1:0] OUT_MISSED = 2'd1;
  localparam logic [1:0] OUT_REJECT = 2'd2;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] task_id;
    logic [15:0] work_units;
    logic [31:0] due_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] task_id_res;
    logic [1:0]  outcome;
    logic [31:0] turnaround;
    logic [31:0] wait_time;
    logic [15:0] done_count;
    logic [15:0] miss_count;
    logic [47:0] sum_turnaround;
    logic [47:0] sum_wait;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       cap_in;
    logic       ins_cmp;
    logic       ins_shift;
    logic       ld_reject;
    logic       ld_retire;
    logic [1:0] retire_outcome;
    logic       at_limit;
    logic       emit;
    logic       pop;
    logic       dec_head;
    logic       adv_now;
  } edf_cmd_t;

  typedef struct packed {
    logic full;
    logic head_valid;
    logic drop_hit;
    logic rem_le1;
    logic out_free;
  } edf_sts_t;

endpackage

FILE: design/edf_ctrl.sv
// Controller state machine of the EDF scheduler.
// Depends on edf_pkg; drives the datapath through edf_cmd_t.
module edf_ctrl
  import edf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_ready,
  input  edf_sts_t sts,
  output edf_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INSCMP = 4'd1;
  localparam logic [3:0] S_INSSH  = 4'd2;
  localparam logic [3:0] S_REJ    = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_RETIRE = 4'd5;
  localparam logic [3:0] S_EMIT   = 4'd6;
  localparam logic [3:0] S_EXEC   = 4'd7;
  localparam logic [3:0] S_ADV    = 4'd8;

  localparam int KW = $clog2(MaxResults + 1);

  logic [3:0]    state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [1:0]    oc_r, oc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      oc_r    <= OUT_DONE;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      oc_r    <= oc_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    oc_nxt    = oc_r;
    cmd       = '0;
    cmd.retire_outcome = oc_r;
    cmd.at_limit = (k_r == KW'(MaxResults - 1));
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          k_nxt      = '0;
          state_nxt  = (in_kind == KIND_TICK) ? S_CHECK : S_INSCMP;
        end
      end
      S_INSCMP: begin
        if (sts.full) begin
          state_nxt = S_REJ;
        end else begin
          cmd.ins_cmp = 1'b1;
          state_nxt   = S_INSSH;
        end
      end
      S_INSSH: begin
        cmd.ins_shift = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_REJ: begin
        cmd.ld_reject = 1'b1;
        oc_nxt        = OUT_REJECT;
        state_nxt     = S_EMIT;
      end
      S_CHECK: begin
        if (k_r < KW'(MaxResults) && sts.head_valid) begin
          if (sts.drop_hit) begin
            oc_nxt    = OUT_MISSED;
            state_nxt = S_RETIRE;
          end else begin
            state_nxt = S_EXEC;
          end
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_EXEC: begin
        cmd.dec_head = 1'b1;
        if (sts.rem_le1) begin
          oc_nxt    = OUT_DONE;
          state_nxt = S_RETIRE;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_RETIRE: begin
        cmd.ld_retire = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (oc_r == OUT_REJECT) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pop   = 1'b1;
            k_nxt     = k_r + KW'(1);
            state_nxt = (oc_r == OUT_MISSED) ? S_CHECK : S_ADV;
          end
        end
      end
      S_ADV: begin
        cmd.adv_now = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/edf_dpath.sv
// Datapath of the EDF scheduler: sorted task table, time, totals, result register.
// Depends on edf_pkg; controlled by edf_ctrl through edf_cmd_t.
module edf_dpath
  import edf_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  edf_cmd_t  cmd,
  output edf_sts_t  sts,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam logic [47:0] SumMax = '1;

  logic        v_r   [TABLE_DEPTH];
  logic [31:0] due_r [TABLE_DEPTH];
  logic [15:0] rem_r [TABLE_DEPTH];
  logic [15:0] work_r[TABLE_DEPTH];
  logic [31:0] arr_r [TABLE_DEPTH];
  logic [15:0] id_r  [TABLE_DEPTH];
  logic        le_r  [TABLE_DEPTH];

  in_item_t    inq_r;
  logic [31:0] now_r;
  logic [15:0] done_cnt_r, miss_cnt_r;
  logic [47:0] sum_ta_r, sum_wt_r;
  logic [15:0] res_id_r;
  logic [1:0]  res_oc_r;
  logic [31:0] res_ta_r, res_wt_r;
  logic        res_last_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [32:0] head_lim, nxt_lim;
  logic [31:0] finish, ta;
  logic [48:0] sum_ta_add, sum_wt_add;
  logic        nxt_result;

  assign head_lim = {17'd0, rem_r[0]} + {1'b0, now_r};
  assign nxt_lim  = {17'd0, rem_r[1]} + {1'b0, now_r};
  assign sts.full       = v_r[TABLE_DEPTH-1];
  assign sts.head_valid = v_r[0];
  assign sts.drop_hit   = {1'b0, due_r[0]} < head_lim;
  assign sts.rem_le1    = rem_r[0] <= 16'd1;
  assign sts.out_free   = !out_valid_r || out_ready;

  // After a drop, another result follows if below the result limit and the new head is dropped or finishes.
  assign nxt_result = !cmd.at_limit && v_r[1] &&
                      (({1'b0, due_r[1]} < nxt_lim) || rem_r[1] <= 16'd1);

  assign finish = (cmd.retire_outcome == OUT_DONE) ? now_r + 32'd1 : now_r;
  assign ta     = finish - arr_r[0];

  assign sum_ta_add = {1'b0, sum_ta_r} + {17'd0, res_ta_r};
  assign sum_wt_add = {1'b0, sum_wt_r} + {17'd0, res_wt_r};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (cmd.ins_shift && !le_r[i]) begin
        if (i == 0 || le_r[(i == 0) ? 0 : i-1]) begin
          v_r[i] <= 1'b1;
        end else begin
          v_r[i] <= v_r[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.pop) begin
        v_r[i] <= (i == TABLE_DEPTH-1) ? 1'b0 : v_r[(i == TABLE_DEPTH-1) ? i : i+1];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.ins_cmp) begin
        le_r[i] <= v_r[i] && (due_r[i] <= inq_r.due_time);
      end
      if (cmd.ins_shift && !le_r[i]) begin
        if (i == 0 || le_r[(i == 0) ? 0 : i-1]) begin
          due_r[i]  <= inq_r.due_time;
          rem_r[i]  <= (inq_r.work_units == 16'd0) ? 16'd1 : inq_r.work_units;
          work_r[i] <= inq_r.work_units;
          arr_r[i]  <= now_r;
          id_r[i]   <= inq_r.task_id;
        end else begin
          due_r[i]  <= due_r[(i == 0) ? 0 : i-1];
          rem_r[i]  <= rem_r[(i == 0) ? 0 : i-1];
          work_r[i] <= work_r[(i == 0) ? 0 : i-1];
          arr_r[i]  <= arr_r[(i == 0) ? 0 : i-1];
          id_r[i]   <= id_r[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.pop && i != TABLE_DEPTH-1) begin
        due_r[i]  <= due_r[(i == TABLE_DEPTH-1) ? i : i+1];
        rem_r[i]  <= rem_r[(i == TABLE_DEPTH-1) ? i : i+1];
        work_r[i] <= work_r[(i == TABLE_DEPTH-1) ? i : i+1];
        arr_r[i]  <= arr_r[(i == TABLE_DEPTH-1) ? i : i+1];
        id_r[i]   <= id_r[(i == TABLE_DEPTH-1) ? i : i+1];
      end else if (cmd.dec_head && i == 0 && rem_r[i] != 16'd0) begin
        rem_r[i] <= rem_r[i] - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      inq_r <= in_data;
    end
    if (cmd.ld_reject) begin
      res_id_r   <= inq_r.task_id;
      res_oc_r   <= OUT_REJECT;
      res_ta_r   <= '0;
      res_wt_r   <= '0;
      res_last_r <= 1'b1;
    end else if (cmd.ld_retire) begin
      res_id_r   <= id_r[0];
      res_oc_r   <= cmd.retire_outcome;
      res_ta_r   <= ta;
      res_wt_r   <= (ta > {16'd0, work_r[0]}) ? ta - {16'd0, work_r[0]} : 32'd0;
      res_last_r <= (cmd.retire_outcome == OUT_DONE) || !nxt_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      done_cnt_r  <= '0;
      miss_cnt_r  <= '0;
      sum_ta_r    <= '0;
      sum_wt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.adv_now) begin
        now_r <= now_r + 32'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit && res_oc_r != OUT_REJECT) begin
        if (res_oc_r == OUT_DONE && done_cnt_r != 16'hFFFF) begin
          done_cnt_r <= done_cnt_r + 16'd1;
        end
        if (res_oc_r == OUT_MISSED && miss_cnt_r != 16'hFFFF) begin
          miss_cnt_r <= miss_cnt_r + 16'd1;
        end
        sum_ta_r <= sum_ta_add[48] ? SumMax : sum_ta_add[47:0];
        sum_wt_r <= sum_wt_add[48] ? SumMax : sum_wt_add[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.task_id_res <= res_id_r;
      out_r.outcome     <= res_oc_r;
      out_r.turnaround  <= res_ta_r;
      out_r.wait_time   <= res_wt_r;
      out_r.last        <= res_last_r;
      if (res_oc_r == OUT_REJECT) begin
        out_r.done_count     <= done_cnt_r;
        out_r.miss_count     <= miss_cnt_r;
        out_r.sum_turnaround <= sum_ta_r;
        out_r.sum_wait       <= sum_wt_r;
      end else begin
        out_r.done_count <= (res_oc_r == OUT_DONE && done_cnt_r != 16'hFFFF) ?
                            done_cnt_r + 16'd1 : done_cnt_r;
        out_r.miss_count <= (res_oc_r == OUT_MISSED && miss_cnt_r != 16'hFFFF) ?
                            miss_cnt_r + 16'd1 : miss_cnt_r;
        out_r.sum_turnaround <= sum_ta_add[48] ? SumMax : sum_ta_add[47:0];
        out_r.sum_wait       <= sum_wt_add[48] ? SumMax : sum_wt_add[47:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/edf_scheduler_with_deadline_drop.sv
// EDF scheduler: an arrival inserts its task into the deadline-sorted table, or sends a
// reject when the table is full; a tick drops doomed head tasks, runs the head and
// retires it when it completes, through the one-entry-at-a-time head retire loop.
// One transaction is worked at a time; results wait in a single output register.
// Synchronous active-low reset empties the task table, zeroes time and all totals.
// Depends on edf_pkg, edf_ctrl, edf_dpath and assert_macros.svh.
`include "assert_macros.svh"
module edf_scheduler_with_deadline_drop
  import edf_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // The controller sequences insertion, the drop loop, execution and time advance.
  // The datapath holds the table as a shift array kept sorted by deadline, so
  // the head is always entry zero and a pop shifts every entry one place toward it.
  edf_cmd_t cmd;
  edf_sts_t sts;

  edf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  edf_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A transaction is never followed by another in the very next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // A rejected task is always the only, and so the last, result of its arrival.
  `ASSERT_IMPLY(a_reject_last, clk, rst_n, out_valid && out_data.outcome == OUT_REJECT, out_data.last)
  // Only the three defined outcome codes ever leave the block.
  `ASSERT_IMPLY(a_outcome_code, clk, rst_n, out_valid, out_data.outcome <= OUT_REJECT)

endmodule

FILE: sim/edf_scheduler_checker.sv
// Checker for the EDF scheduler: watches both channels, keeps its own copy of
// the task table, predicts every result and compares it field by field.
// Depends on edf_pkg.
`timescale 1ns / 100ps
module edf_scheduler_checker
  import edf_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);

  typedef struct {
    logic [31:0] due;
    logic [15:0] rem;
    logic [15:0] work;
    logic [31:0] arrival;
    logic [15:0] id;
  } sched_task_t;

  localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;

  sched_task_t task_list[$];
  out_item_t   result_fifo[$];
  logic [31:0] cur_time;
  logic [15:0] done_total;
  logic [15:0] miss_total;
  logic [47:0] turn_total;
  logic [47:0] wait_total_q;

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? SumMax : s[47:0];
  endfunction

  // Removes the head task and queues its result.
  task automatic retire_front(logic [1:0] outcome, logic [31:0] finish);
    sched_task_t t;
    out_item_t   r;
    t = task_list.pop_front();
    r.turnaround = finish - t.arrival;
    r.wait_time  = (r.turnaround > 32'(t.work)) ? r.turnaround - 32'(t.work) : '0;
    if (outcome == OUT_DONE) begin
      if (done_total != 16'hFFFF) done_total++;
    end else begin
      if (miss_total != 16'hFFFF) miss_total++;
    end
    turn_total   = add_sat48(turn_total, r.turnaround);
    wait_total_q = add_sat48(wait_total_q, r.wait_time);
    r.task_id_res    = t.id;
    r.outcome        = outcome;
    r.done_count     = done_total;
    r.miss_count     = miss_total;
    r.sum_turnaround = turn_total;
    r.sum_wait       = wait_total_q;
    r.last           = 1'b0;
    result_fifo.insert(result_fifo.size(), r);
  endtask

  task automatic schedule_step(in_item_t it);
    sched_task_t t;
    out_item_t   r;
    int          pos;
    int          made;
    made = 0;
    if (it.kind == KIND_ARRIVE) begin
      if (task_list.size() >= DEPTH) begin
        r = '0;
        r.task_id_res = it.task_id;
        r.outcome = OUT_REJECT;
        r.done_count = done_total;
        r.miss_count = miss_total;
        r.sum_turnaround = turn_total;
        r.sum_wait = wait_total_q;
        r.last = 1'b1;
        result_fifo.insert(result_fifo.size(), r);
      end else begin
        pos = 0;
        while (pos < task_list.size() && task_list[pos].due <= it.due_time) pos++;
        t.due = it.due_time;
        t.rem = (it.work_units == 0) ? 16'd1 : it.work_units;
        t.work = it.work_units;
        t.arrival = cur_time;
        t.id = it.task_id;
        task_list.insert(pos, t);
      end
      return;
    end
    // Drop doomed head tasks first; the sum is widened so it cannot wrap.
    while (made < MaxResults && task_list.size() > 0 &&
           {1'b0, task_list[0].due} < 33'(task_list[0].rem) + 33'(cur_time)) begin
      retire_front(OUT_MISSED, cur_time);
      made++;
    end
    if (made < MaxResults && task_list.size() > 0) begin
      if (task_list[0].rem > 0) task_list[0].rem--;
      if (task_list[0].rem == 0) begin
        retire_front(OUT_DONE, cur_time + 32'd1);
        made++;
      end
    end
    cur_time = cur_time + 32'd1;
    if (made > 0) result_fifo[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      task_list.delete();
      result_fifo.delete();
      cur_time = '0;
      done_total = '0;
      miss_total = '0;
      turn_total = '0;
      wait_total_q = '0;
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo.pop_front();
          if (out_data !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Results of this transaction can only appear after this edge.
      if (in_valid && in_ready) schedule_step(in_data);
    end
    pending_count <= result_fifo.size();
  end

endmodule

FILE: sim/edf_scheduler_with_deadline_drop_test.sv
// Testbench top for the EDF scheduler: drives arrival and tick transactions,
// stalls the result side, and gives the verdict. Depends on edf_pkg, the block
// and edf_scheduler_checker.
`timescale 1ns / 100ps
module edf_scheduler_with_deadline_drop_test;
  import edf_pkg::*;

  localparam int Depth      = 16;
  localparam int CycleLimit = 400000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;
  int        result_count;
  int        cycle_count;
  int        sent_count;
  logic      hold_off;     // long receiver stall for the fill-up phase
  logic      calm;         // stretch without random idling

  edf_scheduler_with_deadline_drop #(.TABLE_DEPTH(Depth)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  edf_scheduler_checker #(.DEPTH(Depth)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The cycle counter is the only timeout for the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[edf_scheduler_with_deadline_drop] ERROR");
      $finish;
    end
  end

  // The receiver stalls at random about 22 percent of the time, not at all
  // during the calm stretch, and completely while hold_off is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && (calm || $urandom_range(99) >= 22);
    end
  end

  // Offers one transaction and waits for its acceptance. The sender may idle
  // before offering, so gaps land on every phase of the block.
  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 30) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_arrival(logic [15:0] id, logic [15:0] work, logic [31:0] due);
    in_item_t it;
    it.kind = KIND_ARRIVE;
    it.task_id = id;
    it.work_units = work;
    it.due_time = due;
    send_item(it);
  endtask

  // A tick carries random bits in the ignored fields.
  task automatic send_tick();
    in_item_t it;
    it.kind = KIND_TICK;
    it.task_id = 16'($urandom);
    it.work_units = 16'($urandom);
    it.due_time = $urandom;
    send_item(it);
  endtask

  // Random arrival: mostly short tasks with reachable deadlines near the
  // current time, sometimes extreme values that are dropped or never run.
  task automatic random_arrival(int tick_now);
    logic [15:0] work;
    logic [31:0] due;
    case ($urandom_range(9))
      0: work = 16'($urandom);
      1: work = 16'd0;
      default: work = 16'($urandom_range(1, 6));
    endcase
    case ($urandom_range(9))
      0: due = $urandom;
      1: due = 32'hFFFF_FFFF;
      2: due = 32'(tick_now) + 32'($urandom_range(3));
      default: due = 32'(tick_now) + 32'($urandom_range(2, 40));
    endcase
    send_arrival(16'($urandom), work, due);
  endtask

  initial begin
    int ticks;
    int lap;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 1'b0;
    calm = 1'b0;
    sent_count = 0;
    ticks = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: tick on an empty table, zero work, extreme ids and
    // deadlines, equal deadlines served in arrival order, a deadline already
    // past, and a full table that rejects.
    send_tick(); ticks++;
    send_arrival(16'hFFFF, 16'd0, 32'd5);
    send_arrival(16'h0000, 16'd2, 32'd5);
    send_arrival(16'h1234, 16'd2, 32'd5);
    send_arrival(16'h00AA, 16'hFFFF, 32'hFFFF_FFFF);
    send_arrival(16'h00BB, 16'd3, 32'd0);
    send_arrival(16'h5555, 16'd1, 32'h0000_0000);
    repeat (6) begin
      send_tick(); ticks++;
    end
    for (int i = 0; i < Depth + 2; i++) send_arrival(16'(16'hA000 + i), 16'd1, 32'(100 + i));

    // Fill-up phase: the receiver holds off for a long stretch, counted here
    // in cycles, while ticks keep coming, so the output path backs up.
    hold_off = 1'b1;
    fork
      begin
        int n;
        n = 0;
        while (n < 300) begin
          @(posedge clk);
          n++;
        end
        hold_off = 1'b0;
      end
      begin
        repeat (12) begin
          send_tick(); ticks++;
        end
      end
    join

    // Random part, well-formed bursts of arrivals followed by ticks. Laps 8 to 11
    // run without idling on either side.
    lap = 0;
    while (sent_count < 460) begin
      calm = (lap >= 8 && lap < 12);
      repeat ($urandom_range(1, 6)) random_arrival(ticks);
      repeat ($urandom_range(1, 10)) begin
        send_tick(); ticks++;
      end
      lap++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then a quiet margin for the
    // block's own latency.
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d transactions (%0d ticks), checked %0d results, covering drops,",
             sent_count, ticks, result_count);
    $display("completions, rejects on a full table and a long output stall.");
    if (fail_count == 0) begin
      $display("[edf_scheduler_with_deadline_drop] OK");
    end else begin
      $display("[edf_scheduler_with_deadline_drop] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/edf_pkg.sv
design/edf_ctrl.sv
design/edf_dpath.sv
design/edf_scheduler_with_deadline_drop.sv
sim/edf_scheduler_checker.sv
sim/edf_scheduler_with_deadline_drop_test.sv
